// File: src/sco_pkg.sv
// ----------------------------------------------------------------------------
// sco_pkg
// Shared widths, constants, register indexes and types for the soft-clip
// overdrive pipeline.
// ----------------------------------------------------------------------------
package sco_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int FRAC_BITS   = SAMPLE_BITS - 1;

  // configuration port
  localparam int GAIN_W     = 16;
  localparam int MIX_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_GAIN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIX_PERCENT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EFFECT_ENABLE = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;
  localparam logic [MIX_W-1:0]  MIX_FULL   = 7'd100;

  // gain product and clipper
  localparam int PROD_W  = SAMPLE_BITS + GAIN_W + 1;
  localparam int MAG_A_W = FRAC_BITS + GAIN_W;
  localparam int A3_W    = MAG_A_W + 2;
  localparam int TF_W    = FRAC_BITS;
  localparam int CMAG_W  = FRAC_BITS + 1;
  localparam int SQ_W    = 2 * TF_W;

  localparam logic [A3_W-1:0]   UNIT_A3     = A3_W'(1) << (FRAC_BITS + 8);
  localparam logic [A3_W-1:0]   TWO_UNIT_A3 = A3_W'(1) << (FRAC_BITS + 9);
  localparam logic [CMAG_W-1:0] ONE_MAG     = CMAG_W'(1) << FRAC_BITS;
  localparam logic [SQ_W:0]     KNEE_RND    = (SQ_W + 1)'(3) << (FRAC_BITS - 1);

  // divide by 3 through a reciprocal, one correction step after
  localparam int V3_W = FRAC_BITS + 1;
  localparam int N3   = V3_W + 2;
  localparam int K3_W = N3 - 1;
  localparam logic [K3_W-1:0] K3 = K3_W'((64'd1 << N3) / 64'd3);
  localparam int P3_W = V3_W + K3_W;
  localparam int Q3_W = FRAC_BITS;

  // wet/dry blend and divide by 100 (shift by 2, then reciprocal of 25)
  localparam int WET_W   = FRAC_BITS + 2;
  localparam int SUM_W   = FRAC_BITS + 9;
  localparam int W_W     = FRAC_BITS + 7;
  localparam int V25_W   = W_W - 2;
  localparam int N25     = V25_W + 5;
  localparam int K25_W   = N25 - 4;
  localparam logic [K25_W-1:0] K25 = K25_W'((64'd1 << N25) / 64'd25);
  localparam int P25_W   = V25_W + K25_W;
  localparam int Q25_W   = FRAC_BITS + 1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  localparam sample_t SAMPLE_MAX = sample_t'((64'd1 << FRAC_BITS) - 64'd1);

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic [MIX_W-1:0]  mix;     // already clamped to 100
    logic              enable;
  } cfg_t;

  typedef struct packed {
    sample_t                  x;
    logic signed [PROD_W-1:0] prod;
  } drv_t;

  typedef struct packed {
    sample_t                 x;
    logic signed [WET_W-1:0] wet;
  } wet_t;

endpackage

// File: src/soft_clip_overdrive_mix.sv
// ----------------------------------------------------------------------------
// soft_clip_overdrive_mix
// Pipeline from input transfer to out_valid: gain stage, clip stages, mix stages.
// Throughput: one sample per cycle; a stall on the output backs up through
// the stage valid bits, and empty stages keep taking input meanwhile.
// Reset (rst_n low, synchronous): all stages empty, drive_gain 256,
// mix_percent 100, effect disabled.
// ----------------------------------------------------------------------------
module soft_clip_overdrive_mix import sco_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sample_t               in_sample,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sample_t               out_sample,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [GAIN_W-1:0] drive_gain_r;
  logic [MIX_W-1:0]  mix_percent_r;
  logic              effect_enable_r;
  cfg_t              cfg;

  logic drv_in_ready, drv_valid, clip_ready, clip_valid, mix_ready;
  drv_t drv_data;
  wet_t clip_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_gain_r    <= GAIN_RESET;
      mix_percent_r   <= MIX_FULL;
      effect_enable_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DRIVE_GAIN:    drive_gain_r    <= cfg_data[GAIN_W-1:0];
        REG_MIX_PERCENT:   mix_percent_r   <= cfg_data[MIX_W-1:0];
        REG_EFFECT_ENABLE: effect_enable_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // mix settings above 100 act as fully wet
  assign cfg.gain   = drive_gain_r;
  assign cfg.mix    = (mix_percent_r > MIX_FULL) ? MIX_FULL : mix_percent_r;
  assign cfg.enable = effect_enable_r;

  assign in_stall = !drv_in_ready;

  sco_drive u_drive (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .i_valid (in_valid),
    .i_ready (drv_in_ready),
    .i_x     (in_sample),
    .o_valid (drv_valid),
    .o_ready (clip_ready),
    .o_data  (drv_data)
  );

  sco_clip u_clip (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (drv_valid),
    .i_ready (clip_ready),
    .i_data  (drv_data),
    .o_valid (clip_valid),
    .o_ready (mix_ready),
    .o_data  (clip_data)
  );

  sco_mix u_mix (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .i_valid  (clip_valid),
    .i_ready  (mix_ready),
    .i_data   (clip_data),
    .o_valid  (out_valid),
    .o_ready  (!out_stall),
    .o_sample (out_sample)
  );

`ifndef ASSERT_OFF
  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // input may only back up when every stage is full and the output is held
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall && drv_valid && clip_valid))
    else $error("input stalled with a bubble in the pipeline");
`endif

endmodule

// File: src/sco_drive.sv
// ----------------------------------------------------------------------------
// sco_drive
// Input stage: registers the sample and its product with the Q8.8 drive gain.
// ----------------------------------------------------------------------------
module sco_drive import sco_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    i_valid,
  output logic    i_ready,
  input  sample_t i_x,
  output logic    o_valid,
  input  logic    o_ready,
  output drv_t    o_data
);

  logic                     valid_r;
  drv_t                     data_r;
  logic signed [GAIN_W:0]   gain_s;
  logic signed [PROD_W-1:0] prod_nxt;

  assign i_ready  = !valid_r || o_ready;
  assign gain_s   = $signed({1'b0, cfg.gain});
  assign prod_nxt = PROD_W'(i_x) * PROD_W'(gain_s);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (i_ready) begin
      valid_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (i_ready && i_valid) begin
      data_r.x    <= i_x;
      data_r.prod <= prod_nxt;
    end
  end

  assign o_valid = valid_r;
  assign o_data  = data_r;

endmodule

// File: src/sco_clip.sv
// ----------------------------------------------------------------------------
// sco_clip
// Odd-symmetric piecewise quadratic soft clipper, five register stages:
// magnitude, region/knee term, square, scaled reciprocal of 3, wet value.
// ----------------------------------------------------------------------------
module sco_clip import sco_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic i_valid,
  output logic i_ready,
  input  drv_t i_data,
  output logic o_valid,
  input  logic o_ready,
  output wet_t o_data
);

  localparam logic [MAG_A_W:0] LIN_RND = (MAG_A_W + 1)'(64);

  // stage valids and ready chain
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  // stage 1: sign and magnitude
  sample_t              x1_r;
  logic                 neg1_r;
  logic [MAG_A_W-1:0]   a1_r;
  logic signed [PROD_W-1:0] prod_neg;
  logic [MAG_A_W-1:0]   a1_nxt;

  // stage 2: region decision
  sample_t              x2_r;
  logic                 neg2_r, knee2_r;
  logic [TF_W-1:0]      tf2_r;
  logic [CMAG_W-1:0]    mag2_r;
  logic [A3_W-1:0]      a3;
  logic [A3_W-1:0]      t_full;
  logic [MAG_A_W:0]     lin_sum;
  logic                 is_lin, is_knee;
  logic [CMAG_W-1:0]    mag2_nxt;

  // stage 3: square of the knee term
  sample_t              x3_r;
  logic                 neg3_r, knee3_r;
  logic [CMAG_W-1:0]    mag3_r;
  logic [SQ_W-1:0]      sq3_r;

  // stage 4: rounded square over 2^F, times reciprocal of 3
  sample_t              x4_r;
  logic                 neg4_r, knee4_r;
  logic [CMAG_W-1:0]    mag4_r;
  logic [V3_W-1:0]      vq4_r;
  logic [P3_W-1:0]      p4_r;
  logic [SQ_W:0]        u_sum;
  logic [V3_W-1:0]      v4_nxt;

  // stage 5: quotient fixup and signed wet value
  wet_t                 d5_r;
  logic [Q3_W-1:0]      q0;
  logic [3:0]           q0_x3, rem3;
  logic [Q3_W-1:0]      q3;
  logic [CMAG_W-1:0]    mag5;
  logic [WET_W-1:0]     mag_ext;
  logic signed [WET_W-1:0] wet_nxt;

  assign rdy5    = !v5_r || o_ready;
  assign rdy4    = !v4_r || rdy5;
  assign rdy3    = !v3_r || rdy4;
  assign rdy2    = !v2_r || rdy3;
  assign rdy1    = !v1_r || rdy2;
  assign i_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= i_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  // stage 1
  assign prod_neg = -i_data.prod;
  assign a1_nxt   = i_data.prod[PROD_W-1] ? prod_neg[MAG_A_W-1:0]
                                          : i_data.prod[MAG_A_W-1:0];

  always_ff @(posedge clk) begin
    if (rdy1 && i_valid) begin
      x1_r   <= i_data.x;
      neg1_r <= i_data.prod[PROD_W-1];
      a1_r   <= a1_nxt;
    end
  end

  // stage 2: compare 3|s| against 1.0 and 2.0 exactly
  assign a3       = (A3_W'(a1_r) << 1) + A3_W'(a1_r);
  assign is_lin   = (a3 <= UNIT_A3);
  assign is_knee  = !is_lin && (a3 <= TWO_UNIT_A3);
  assign t_full   = TWO_UNIT_A3 - a3;
  assign lin_sum  = (MAG_A_W + 1)'(a1_r) + LIN_RND;
  assign mag2_nxt = is_lin ? lin_sum[CMAG_W+6:7] : ONE_MAG;

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      x2_r    <= x1_r;
      neg2_r  <= neg1_r;
      knee2_r <= is_knee;
      tf2_r   <= t_full[TF_W+7:8];
      mag2_r  <= mag2_nxt;
    end
  end

  // stage 3
  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      x3_r    <= x2_r;
      neg3_r  <= neg2_r;
      knee3_r <= knee2_r;
      mag3_r  <= mag2_r;
      sq3_r   <= tf2_r * tf2_r;
    end
  end

  // stage 4: floor((sq + 1.5*2^F) / (3*2^F)) = floor(v / 3)
  assign u_sum  = (SQ_W + 1)'(sq3_r) + KNEE_RND;
  assign v4_nxt = u_sum[SQ_W:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      x4_r    <= x3_r;
      neg4_r  <= neg3_r;
      knee4_r <= knee3_r;
      mag4_r  <= mag3_r;
      vq4_r   <= v4_nxt;
      p4_r    <= P3_W'(v4_nxt) * P3_W'(K3);
    end
  end

  // stage 5: estimate is at most one short; remainder is below 6
  assign q0      = p4_r[N3 +: Q3_W];
  assign q0_x3   = {q0[2:0], 1'b0} + q0[3:0];
  assign rem3    = vq4_r[3:0] - q0_x3;
  assign q3      = q0 + Q3_W'(rem3 >= 4'd3);
  assign mag5    = knee4_r ? (ONE_MAG - CMAG_W'(q3)) : mag4_r;
  assign mag_ext = WET_W'(mag5);
  assign wet_nxt = neg4_r ? -$signed(mag_ext) : $signed(mag_ext);

  always_ff @(posedge clk) begin
    if (rdy5 && v4_r) begin
      d5_r.x   <= x4_r;
      d5_r.wet <= wet_nxt;
    end
  end

  assign o_valid = v5_r;
  assign o_data  = d5_r;

endmodule

// File: src/sco_mix.sv
// ----------------------------------------------------------------------------
// sco_mix
// Wet/dry blend, divide by 100 rounded half away from zero, saturation and
// bypass select. Four register stages, the last one is the output register.
// ----------------------------------------------------------------------------
module sco_mix import sco_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    i_valid,
  output logic    i_ready,
  input  wet_t    i_data,
  output logic    o_valid,
  input  logic    o_ready,
  output sample_t o_sample
);

  localparam logic [W_W-1:0] DIV_RND = W_W'(50);

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  // stage 1: weighted sum
  sample_t                  x1_r;
  logic signed [SUM_W-1:0]  sum1_r;
  logic [MIX_W-1:0]         dry_mix;
  logic signed [MIX_W:0]    wet_k, dry_k;
  logic signed [SUM_W-1:0]  wet_term, dry_term;

  // stage 2: magnitude plus half divisor
  sample_t                  x2_r;
  logic                     neg2_r;
  logic [W_W-1:0]           w2_r;
  logic signed [SUM_W-1:0]  sum_neg;
  logic [SUM_W-1:0]         sum_abs;

  // stage 3: times reciprocal of 25
  sample_t                  x3_r;
  logic                     neg3_r;
  logic [V25_W-1:0]         vq3_r;
  logic [P25_W-1:0]         p3_r;
  logic [V25_W-1:0]         v25;

  // stage 4: fixup, sign, saturation, bypass select
  sample_t                  out_r;
  logic [Q25_W-1:0]         q0;
  logic [5:0]               q0_x25, rem25;
  logic [Q25_W-1:0]         q25;
  sample_t                  q_s, pos_val, res;

  assign rdy4    = !v4_r || o_ready;
  assign rdy3    = !v3_r || rdy4;
  assign rdy2    = !v2_r || rdy3;
  assign rdy1    = !v1_r || rdy2;
  assign i_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= i_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // stage 1
  assign dry_mix  = MIX_FULL - cfg.mix;
  assign wet_k    = $signed({1'b0, cfg.mix});
  assign dry_k    = $signed({1'b0, dry_mix});
  assign wet_term = SUM_W'(i_data.wet) * SUM_W'(wet_k);
  assign dry_term = SUM_W'(i_data.x) * SUM_W'(dry_k);

  always_ff @(posedge clk) begin
    if (rdy1 && i_valid) begin
      x1_r   <= i_data.x;
      sum1_r <= wet_term + dry_term;
    end
  end

  // stage 2
  assign sum_neg = -sum1_r;
  assign sum_abs = sum1_r[SUM_W-1] ? sum_neg : sum1_r;

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      x2_r   <= x1_r;
      neg2_r <= sum1_r[SUM_W-1];
      w2_r   <= W_W'(sum_abs) + DIV_RND;
    end
  end

  // stage 3: floor(w / 100) = floor(floor(w / 4) / 25)
  assign v25 = w2_r[W_W-1:2];

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      x3_r   <= x2_r;
      neg3_r <= neg2_r;
      vq3_r  <= v25;
      p3_r   <= P25_W'(v25) * P25_W'(K25);
    end
  end

  // stage 4: estimate at most one short, remainder below 50
  assign q0      = p3_r[N25 +: Q25_W];
  assign q0_x25  = {q0[1:0], 4'b0000} + {q0[2:0], 3'b000} + q0[5:0];
  assign rem25   = vq3_r[5:0] - q0_x25;
  assign q25     = q0 + Q25_W'(rem25 >= 6'd25);
  assign q_s     = sample_t'(q25);
  // magnitude never exceeds 2^F, so only the positive side can clip
  assign pos_val = q25[FRAC_BITS] ? SAMPLE_MAX : q_s;
  assign res     = neg3_r ? -q_s : pos_val;

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      out_r <= cfg.enable ? res : x3_r;
    end
  end

  assign o_valid  = v4_r;
  assign o_sample = out_r;

endmodule
